// File: src/ghwa_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ghwa_pkg
// Shared types, constants and helpers for the gyro history window average.
// ---------------------------------------------------------------------------
package ghwa_pkg;

   localparam int DEPTH = 64;
   localparam int AW    = $clog2(DEPTH);

   localparam int TW  = 48;   // timestamp width
   localparam int RW  = 32;   // Q16.16 rate width
   localparam int DW  = 14;   // one pair duration, at most the gap limit
   localparam int CW  = 18;   // covered time, at most the window limit
   localparam int SW  = 51;   // signed sum of rate times duration
   localparam int CNW = $clog2(SW);

   localparam logic [TW-1:0] MAX_WINDOW_US = TW'(200000);
   localparam logic [TW-1:0] MAX_GAP_US    = TW'(10000);

   localparam logic [1:0] MODE_CLEAR   = 2'd0;
   localparam logic [1:0] MODE_PUSH    = 2'd1;
   localparam logic [1:0] MODE_AVERAGE = 2'd2;
   localparam logic [1:0] MODE_LOOKUP  = 2'd3;

   typedef struct packed {
      logic [TW-1:0]        stamp;
      logic signed [RW-1:0] x;
      logic signed [RW-1:0] y;
      logic signed [RW-1:0] z;
   } entry_type;

   // ring position of the k-th oldest sample
   function automatic logic [AW-1:0] slot_f(input logic [AW-1:0] base,
                                            input logic [AW:0]   k);
      logic [AW+1:0] sum;
      sum = {2'b00, base} + {1'b0, k};
      if (sum >= (AW+2)'(DEPTH)) begin
         sum = sum - (AW+2)'(DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   function automatic logic signed [RW-1:0] axis_rate_f(input entry_type en,
                                                        input logic [1:0] ax);
      logic signed [RW-1:0] r;
      case (ax)
         2'd0:    r = en.x;
         2'd1:    r = en.y;
         default: r = en.z;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

// File: src/gyro_history_window_average.sv
`default_nettype none
// ---------------------------------------------------------------------------
// gyro_history_window_average
// Ring store of timestamped three-axis gyro samples with time-weighted
// window average and interval lookup, run by one small sequencer.
// ---------------------------------------------------------------------------
// A word is taken when start is high and busy is low; busy stays high until
// the single result word appears on the rsp_ ports for one cycle with
// rsp_valid, and the receiver cannot stall it. Every read goes through the
// one registered read port of the sample memory, and one multiplier and one
// restoring divider are shared by the three axes. Clear answers straight from
// idle; push reads the oldest and newest samples, then writes; lookup does a
// binary search over the stored samples; average walks the stored pairs,
// multiplies each pair that overlaps the window per axis, then divides each sum.
// ---------------------------------------------------------------------------
module gyro_history_window_average import ghwa_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic [1:0]           req_mode,
   input  wire logic [TW-1:0]        req_time_us,
   input  wire logic [TW-1:0]        req_end_us,
   input  wire logic signed [RW-1:0] req_gyro_x,
   input  wire logic signed [RW-1:0] req_gyro_y,
   input  wire logic signed [RW-1:0] req_gyro_z,
   input  wire logic                 req_tail,
   output logic                      rsp_valid,
   output logic                      rsp_ok,
   output logic signed [RW-1:0]      rsp_rate_x,
   output logic signed [RW-1:0]      rsp_rate_y,
   output logic signed [RW-1:0]      rsp_rate_z,
   output logic [TW-1:0]             rsp_next_us,
   output logic [TW-1:0]             rsp_held_sample_us
);

   localparam logic [4:0] S_IDLE     = 5'd0;
   localparam logic [4:0] S_RD_OLD   = 5'd1;
   localparam logic [4:0] S_RD_NEW   = 5'd2;
   localparam logic [4:0] S_CHECK    = 5'd3;
   localparam logic [4:0] S_AV_FIRST = 5'd4;
   localparam logic [4:0] S_AV_LOAD  = 5'd5;
   localparam logic [4:0] S_AV_ADDR  = 5'd6;
   localparam logic [4:0] S_AV_PAIR  = 5'd7;
   localparam logic [4:0] S_AV_MUL   = 5'd8;
   localparam logic [4:0] S_AV_ACC   = 5'd9;
   localparam logic [4:0] S_DIV_INIT = 5'd10;
   localparam logic [4:0] S_DIV_LOAD = 5'd11;
   localparam logic [4:0] S_DIV_STEP = 5'd12;
   localparam logic [4:0] S_DIV_DONE = 5'd13;
   localparam logic [4:0] S_LK_LOOP  = 5'd14;
   localparam logic [4:0] S_LK_CMP   = 5'd15;
   localparam logic [4:0] S_LK_RDA   = 5'd16;
   localparam logic [4:0] S_LK_RDB   = 5'd17;
   localparam logic [4:0] S_LK_FIN   = 5'd18;

   entry_type mem [DEPTH];
   entry_type rd_q_ff;
   logic [AW-1:0] rd_addr, wr_addr;
   logic          wr_en;

   logic [4:0]    state_ff, state_in;
   logic [AW-1:0] oldest_ff, oldest_in;
   logic [AW:0]   fill_ff, fill_in;
   logic [1:0]    mode_ff, mode_in;
   entry_type     req_ff, req_in;
   logic [TW-1:0] end_ff, end_in;
   logic          tail_ff, tail_in;
   logic [TW-1:0] old_stamp_ff, old_stamp_in;
   logic [AW:0]   k_ff, k_in;
   logic [AW:0]   hi_ff, hi_in;
   logic [AW:0]   mid_ff, mid_in;
   entry_type     prev_ff, prev_in;
   entry_type     cur_ff, cur_in;
   logic [DW-1:0] d_ff, d_in;
   logic [1:0]    axis_ff, axis_in;
   logic signed [RW+DW:0] prod_ff, prod_in;
   logic signed [SW-1:0]  sum_ff [3];
   logic signed [SW-1:0]  sum_in [3];
   logic [CW-1:0] cov_ff, cov_in;
   logic [SW-1:0] dvd_ff, dvd_in;
   logic [CW-1:0] rem_ff, rem_in;
   logic [CNW-1:0] cnt_ff, cnt_in;
   logic          neg_ff, neg_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_ok_ff, rsp_ok_in;
   logic signed [RW-1:0] rate_ff [3];
   logic signed [RW-1:0] rate_in [3];
   logic [TW-1:0] next_ff, next_in;
   logic [TW-1:0] held_ff, held_in;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= req_ff;
      end
      rd_q_ff <= mem[rd_addr];
   end

   always_comb begin
      logic [TW-1:0] span;
      logic [TW-1:0] lt, rt, lo_t, hi_t, stop;
      logic          fail;
      logic          e_le_s;
      logic [AW:0]   k_next;
      logic [CW:0]   rs;
      logic [RW-1:0] q;

      state_in     = state_ff;
      oldest_in    = oldest_ff;
      fill_in      = fill_ff;
      mode_in      = mode_ff;
      req_in       = req_ff;
      end_in       = end_ff;
      tail_in      = tail_ff;
      old_stamp_in = old_stamp_ff;
      k_in         = k_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      prev_in      = prev_ff;
      cur_in       = cur_ff;
      d_in         = d_ff;
      axis_in      = axis_ff;
      prod_in      = prod_ff;
      sum_in       = sum_ff;
      cov_in       = cov_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      neg_in       = neg_ff;
      rsp_valid_in = 1'b0;
      rsp_ok_in    = rsp_ok_ff;
      rate_in      = rate_ff;
      next_in      = next_ff;
      held_in      = held_ff;
      rd_addr      = slot_f(oldest_ff, k_ff);
      wr_en        = 1'b0;
      wr_addr      = slot_f(oldest_ff, fill_ff);
      fail         = 1'b0;
      span         = end_ff - req_ff.stamp;
      e_le_s       = end_ff <= req_ff.stamp;
      lt           = prev_ff.stamp;
      rt           = rd_q_ff.stamp;
      lo_t         = (lt > req_ff.stamp) ? lt : req_ff.stamp;
      hi_t         = (rt < end_ff) ? rt : end_ff;
      stop         = end_ff;
      k_next       = k_ff + 1'b1;
      rs           = {rem_ff, dvd_ff[SW-1]};
      q            = dvd_ff[RW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               mode_in  = req_mode;
               req_in   = '{stamp: req_time_us, x: req_gyro_x, y: req_gyro_y, z: req_gyro_z};
               end_in   = req_end_us;
               tail_in  = req_tail;
               if (req_mode == MODE_CLEAR) begin
                  oldest_in    = '0;
                  fill_in      = '0;
                  rsp_valid_in = 1'b1;
                  rsp_ok_in    = 1'b1;
                  rate_in      = '{default: '0};
                  next_in      = '0;
                  held_in      = '0;
               end else begin
                  state_in = S_RD_OLD;
               end
            end
         end
         S_RD_OLD: begin
            rd_addr  = oldest_ff;
            state_in = S_RD_NEW;
         end
         S_RD_NEW: begin
            old_stamp_in = rd_q_ff.stamp;
            rd_addr      = slot_f(oldest_ff, (fill_ff == '0) ? '0 : fill_ff - 1'b1);
            state_in     = S_CHECK;
         end
         S_CHECK: begin
            // rd_q_ff holds the newest sample here
            unique case (mode_ff)
               MODE_PUSH: begin
                  if (fill_ff != '0 && req_ff.stamp <= rd_q_ff.stamp) begin
                     fail = 1'b1;
                  end else begin
                     wr_en = 1'b1;
                     if (fill_ff == (AW+1)'(DEPTH)) begin
                        wr_addr   = oldest_ff;
                        oldest_in = slot_f(oldest_ff, (AW+1)'(1));
                     end else begin
                        fill_in = fill_ff + 1'b1;
                     end
                     rsp_valid_in = 1'b1;
                     rsp_ok_in    = 1'b1;
                     rate_in      = '{default: '0};
                     next_in      = '0;
                     held_in      = '0;
                     state_in     = S_IDLE;
                  end
               end
               MODE_AVERAGE: begin
                  if (fill_ff < (AW+1)'(2) || e_le_s || span > MAX_WINDOW_US ||
                      req_ff.stamp < old_stamp_ff || end_ff > rd_q_ff.stamp) begin
                     fail = 1'b1;
                  end else begin
                     sum_in   = '{default: '0};
                     cov_in   = '0;
                     state_in = S_AV_FIRST;
                  end
               end
               MODE_LOOKUP: begin
                  if (fill_ff == '0 || e_le_s || req_ff.stamp < old_stamp_ff ||
                      (end_ff > rd_q_ff.stamp &&
                       (!tail_ff || end_ff - rd_q_ff.stamp > MAX_GAP_US))) begin
                     fail = 1'b1;
                  end else begin
                     k_in     = '0;
                     hi_in    = fill_ff;
                     state_in = S_LK_LOOP;
                  end
               end
               default: begin
                  fail = 1'b1;
               end
            endcase
         end
         S_AV_FIRST: begin
            rd_addr  = oldest_ff;
            state_in = S_AV_LOAD;
         end
         S_AV_LOAD: begin
            prev_in  = rd_q_ff;
            k_in     = (AW+1)'(1);
            state_in = S_AV_ADDR;
         end
         S_AV_ADDR: begin
            state_in = S_AV_PAIR;
         end
         S_AV_PAIR: begin
            if (lt >= end_ff) begin
               state_in = S_DIV_INIT;
            end else if (rt <= req_ff.stamp) begin
               prev_in  = rd_q_ff;
               k_in     = k_next;
               state_in = (k_next == fill_ff) ? S_DIV_INIT : S_AV_ADDR;
            end else if (rt - lt > MAX_GAP_US) begin
               fail = 1'b1;
            end else begin
               d_in     = DW'(hi_t - lo_t);
               cov_in   = cov_ff + CW'(hi_t - lo_t);
               cur_in   = rd_q_ff;
               axis_in  = 2'd0;
               state_in = S_AV_MUL;
            end
         end
         S_AV_MUL: begin
            prod_in  = axis_rate_f(prev_ff, axis_ff) * $signed({1'b0, d_ff});
            state_in = S_AV_ACC;
         end
         S_AV_ACC: begin
            sum_in[axis_ff] = sum_ff[axis_ff] + SW'(prod_ff);
            if (axis_ff == 2'd2) begin
               prev_in  = cur_ff;
               k_in     = k_next;
               state_in = (k_next == fill_ff) ? S_DIV_INIT : S_AV_ADDR;
            end else begin
               axis_in  = axis_ff + 1'b1;
               state_in = S_AV_MUL;
            end
         end
         S_DIV_INIT: begin
            if ({{(TW-CW){1'b0}}, cov_ff} != span || cov_ff == '0) begin
               fail = 1'b1;
            end else begin
               axis_in  = 2'd0;
               state_in = S_DIV_LOAD;
            end
         end
         S_DIV_LOAD: begin
            neg_in   = sum_ff[axis_ff][SW-1];
            dvd_in   = sum_ff[axis_ff][SW-1] ? SW'(-sum_ff[axis_ff]) : SW'(sum_ff[axis_ff]);
            rem_in   = '0;
            cnt_in   = '0;
            state_in = S_DIV_STEP;
         end
         S_DIV_STEP: begin
            // restoring division, one quotient bit a cycle
            if (rs >= {1'b0, cov_ff}) begin
               rem_in = CW'(rs - {1'b0, cov_ff});
               dvd_in = {dvd_ff[SW-2:0], 1'b1};
            end else begin
               rem_in = rs[CW-1:0];
               dvd_in = {dvd_ff[SW-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNW'(SW-1)) begin
               state_in = S_DIV_DONE;
            end
         end
         S_DIV_DONE: begin
            rate_in[axis_ff] = neg_ff ? -q : q;
            if (axis_ff == 2'd2) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = 1'b1;
               next_in      = '0;
               held_in      = '0;
               state_in     = S_IDLE;
            end else begin
               axis_in  = axis_ff + 1'b1;
               state_in = S_DIV_LOAD;
            end
         end
         S_LK_LOOP: begin
            if (k_ff + 1'b1 < hi_ff) begin
               mid_in   = k_ff + ((hi_ff - k_ff) >> 1);
               rd_addr  = slot_f(oldest_ff, k_ff + ((hi_ff - k_ff) >> 1));
               state_in = S_LK_CMP;
            end else begin
               state_in = S_LK_RDA;
            end
         end
         S_LK_CMP: begin
            if (rd_q_ff.stamp <= req_ff.stamp) begin
               k_in = mid_ff;
            end else begin
               hi_in = mid_ff;
            end
            state_in = S_LK_LOOP;
         end
         S_LK_RDA: begin
            state_in = S_LK_RDB;
         end
         S_LK_RDB: begin
            prev_in  = rd_q_ff;
            rd_addr  = slot_f(oldest_ff, k_next);
            state_in = S_LK_FIN;
         end
         S_LK_FIN: begin
            if (k_next < fill_ff) begin
               if (rt - lt > MAX_GAP_US) begin
                  fail = 1'b1;
               end
               if (rt < end_ff) begin
                  stop = rt;
               end
            end else if (!tail_ff || end_ff - lt > MAX_GAP_US) begin
               fail = 1'b1;
            end
            if (stop <= req_ff.stamp) begin
               fail = 1'b1;
            end
            if (!fail) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = 1'b1;
               rate_in[0]   = prev_ff.x;
               rate_in[1]   = prev_ff.y;
               rate_in[2]   = prev_ff.z;
               next_in      = stop;
               held_in      = lt;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (fail) begin
         rsp_valid_in = 1'b1;
         rsp_ok_in    = 1'b0;
         rate_in      = '{default: '0};
         next_in      = '0;
         held_in      = '0;
         state_in     = S_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         oldest_ff    <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         oldest_ff    <= oldest_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      req_ff       <= req_in;
      end_ff       <= end_in;
      tail_ff      <= tail_in;
      old_stamp_ff <= old_stamp_in;
      k_ff         <= k_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      prev_ff      <= prev_in;
      cur_ff       <= cur_in;
      d_ff         <= d_in;
      axis_ff      <= axis_in;
      prod_ff      <= prod_in;
      sum_ff       <= sum_in;
      cov_ff       <= cov_in;
      dvd_ff       <= dvd_in;
      rem_ff       <= rem_in;
      cnt_ff       <= cnt_in;
      neg_ff       <= neg_in;
      rsp_ok_ff    <= rsp_ok_in;
      rate_ff      <= rate_in;
      next_ff      <= next_in;
      held_ff      <= held_in;
   end

   assign busy               = (state_ff != S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_ok             = rsp_ok_ff;
   assign rsp_rate_x         = rate_ff[0];
   assign rsp_rate_y         = rate_ff[1];
   assign rsp_rate_z         = rate_ff[2];
   assign rsp_next_us        = next_ff;
   assign rsp_held_sample_us = held_ff;

endmodule
`default_nettype wire
